/* rtl/rational_arithmetic_unit_macros.svh */
// Assertion macros shared by the rational arithmetic unit.
// Depends on nothing; included by modules that carry assertions.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RAU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* rtl/rau_pkg.sv */
// Package of the rational arithmetic unit: action codes, status codes, order codes, sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int unsigned Width = 32;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0, ACT_SUB = 3'd1, ACT_MUL = 3'd2,
    ACT_DIV = 3'd3, ACT_CMP = 3'd4, ACT_NEG = 3'd5
  } action_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [1:0] ORD_EQ = 2'd0;
  localparam logic [1:0] ORD_LT = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_e;
endpackage

/* rtl/rau_divider.sv */
// Shared restoring divider, one quotient bit per cycle, used for gcd remainders
// and for the final exact divisions. Depends on nothing.
`timescale 1ns / 1ps
module rau_divider #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dvd_i,
  input  logic [W-1:0] dvs_i,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic [W-1:0]    quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [W:0]      trial;
  logic [W-1:0]    step_quo, step_rem;

  // One shift-subtract step on the running remainder.
  always_comb begin
    trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
    if (!trial[W]) begin
      step_rem = trial[W-1:0];
      step_quo = {quo_q[W-2:0], 1'b1};
    end else begin
      step_rem = {rem_q[W-2:0], quo_q[W-1]};
      step_quo = {quo_q[W-2:0], 1'b0};
    end
  end

  // Load a new division on start, otherwise step while running.
  always_comb begin
    cnt_d = cnt_q;
    run_d = run_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CntW'(W);
      quo_d = dvd_i;
      rem_d = '0;
      dvs_d = dvs_i;
    end else if (run_q) begin
      rem_d = step_rem;
      quo_d = step_quo;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // The final step's quotient and remainder are shown in the done cycle.
  assign done_o = run_q && (cnt_q == CntW'(1));
  assign quo_o  = step_quo;
  assign rem_o  = step_rem;
endmodule

/* rtl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: sequencer, one shared 32x32 multiplier
// and the shared divider. Depends on rau_pkg, rau_divider and the macro header.
//
//   channel   direction  handshake         fields
//   command   in         start / busy      action_i a_num_i a_den_i b_num_i b_den_i
//   result    out        done_o strobe     res_num_o res_den_o order_o status_o
//
// An arithmetic beat passes the multiply states S_MUL1 to S_MUL3, the combine state,
// one divider run per Euclid remainder step (k steps, 1 to about 90), a launch in
// S_GCD, the exact divisions of numerator and denominator and the closing state,
// after which the result beat follows. Zero-denominator errors and unused actions go
// from acceptance straight to the closing state, compare after the combine state.
// Reset clears the sequencer; busy is high from acceptance until the result beat.
// The receiver cannot stall: the result is shown for one cycle with done_o.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_macros.svh"
module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = rau_pkg::Width
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  output logic        done_o,
  output logic signed [31:0] res_num_o,
  output logic [30:0] res_den_o,
  output logic [1:0]  order_o,
  output logic [1:0]  status_o
);
  rau_pkg::state_e state_q, state_d;
  logic [2:0]  act_q, act_d;
  logic [31:0] an_q, ad_q, bn_q, bd_q, an_d, ad_d, bn_d, bd_d;
  logic [63:0] p1_q, p1_d, p2_q, p2_d;
  logic        s1_q, s1_d, s2_q, s2_d;
  logic [63:0] num_q, num_d, den_q, den_d, gx_q, gx_d, gy_q, gy_d, n_q, n_d;
  logic        nneg_q, nneg_d;
  logic        dn_q, dn_d;
  logic [31:0] rn_q, rn_d;
  logic [30:0] rd_q, rd_d;
  logic [1:0]  ord_q, ord_d, st_q, st_d;

  // Shared multiplier over magnitudes.
  logic [31:0] ma, mb;
  logic        mna, mnb;
  logic [63:0] mp;
  assign mp = 64'(ma) * 64'(mb);

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  logic        dv_start, dv_done;
  logic [63:0] dv_a, dv_b, dv_q, dv_r;
  rau_divider #(.W(64)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .dvd_i(dv_a), .dvs_i(dv_b),
    .done_o(dv_done), .quo_o(dv_q), .rem_o(dv_r)
  );

  logic [63:0] maxpos;
  logic [64:0] sum;
  logic        negx, negy;
  assign maxpos = (64'd1 << (WIDTH - 1)) - 64'd1;

  // Sequencer.
  always_comb begin
    state_d = state_q; act_d = act_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    p1_d = p1_q; p2_d = p2_q; s1_d = s1_q; s2_d = s2_q;
    num_d = num_q; den_d = den_q; gx_d = gx_q; gy_d = gy_q; n_d = n_q;
    nneg_d = nneg_q; dn_d = 1'b0;
    rn_d = rn_q; rd_d = rd_q; ord_d = ord_q; st_d = st_q;
    ma = '0; mb = '0; mna = 1'b0; mnb = 1'b0;
    dv_start = 1'b0; dv_a = gx_q; dv_b = gy_q;
    sum = '0; negx = 1'b0; negy = 1'b0;
    unique case (state_q)
      rau_pkg::S_IDLE: begin
        if (start) begin
          act_d = action_i; an_d = a_num_i; ad_d = a_den_i;
          bn_d = b_num_i; bd_d = b_den_i;
          rn_d = '0; rd_d = '0; ord_d = rau_pkg::ORD_EQ; st_d = rau_pkg::ST_OK;
          if (action_i > 3'(rau_pkg::ACT_NEG)) begin
            state_d = rau_pkg::S_DONE;
          end else if (a_den_i == '0 || (action_i != 3'(rau_pkg::ACT_NEG)
                       && (b_den_i == '0 || (action_i == 3'(rau_pkg::ACT_DIV)
                       && b_num_i == '0)))) begin
            st_d = rau_pkg::ST_ZDEN; state_d = rau_pkg::S_DONE;
          end else begin
            state_d = rau_pkg::S_MUL1;
          end
        end
      end
      // First product: numerator term x (a_num*b_num for mul, -a_num for neg, a_num*b_den else).
      rau_pkg::S_MUL1: begin
        ma = mag32(an_q); mna = an_q[31];
        if (act_q == 3'(rau_pkg::ACT_MUL)) begin
          mb = mag32(bn_q); mnb = bn_q[31];
        end else if (act_q == 3'(rau_pkg::ACT_NEG)) begin
          mb = 32'd1; mnb = 1'b1;
        end else begin
          mb = mag32(bd_q); mnb = bd_q[31];
        end
        p1_d = mp; s1_d = (mna != mnb) && mp != '0;
        state_d = rau_pkg::S_MUL2;
      end
      // Second product: b_num*a_den, or the denominator for mul/div/neg.
      rau_pkg::S_MUL2: begin
        ma = mag32(ad_q); mna = ad_q[31];
        if (act_q == 3'(rau_pkg::ACT_NEG)) begin
          mb = 32'd1; mnb = 1'b0;
        end else if (act_q == 3'(rau_pkg::ACT_MUL)) begin
          mb = mag32(bd_q); mnb = bd_q[31];
        end else begin
          mb = mag32(bn_q); mnb = bn_q[31];
        end
        p2_d = mp; s2_d = (mna != mnb) && mp != '0;
        state_d = rau_pkg::S_MUL3;
      end
      // Third product: a_den*b_den for add/sub/cmp; the pair is then combined.
      rau_pkg::S_MUL3: begin
        ma = mag32(ad_q); mna = ad_q[31]; mb = mag32(bd_q); mnb = bd_q[31];
        den_d = mp; nneg_d = (mna != mnb);
        state_d = rau_pkg::S_COMB;
      end
      rau_pkg::S_COMB: begin
        negx = s1_q;
        negy = (act_q == 3'(rau_pkg::ACT_ADD)) ? s2_q : (s2_q ^ (p2_q != '0));
        if (negx == negy) begin
          sum = {1'b0, p1_q} + {1'b0, p2_q};
        end else if (p1_q >= p2_q) begin
          sum = {1'b0, p1_q - p2_q};
        end else begin
          sum = {1'b0, p2_q - p1_q}; negx = negy;
        end
        if (sum == '0) negx = 1'b0;
        unique case (act_q)
          3'(rau_pkg::ACT_ADD), 3'(rau_pkg::ACT_SUB): begin
            num_d = sum[63:0]; s1_d = negx;
            s2_d = nneg_q;
          end
          3'(rau_pkg::ACT_CMP): begin
            ord_d = (sum == '0) ? rau_pkg::ORD_EQ :
                    ((negx ^ nneg_q) ? rau_pkg::ORD_LT : rau_pkg::ORD_GT);
          end
          default: begin
            num_d = p1_q; den_d = p2_q; s2_d = s2_q;
          end
        endcase
        gx_d = (act_q == 3'(rau_pkg::ACT_ADD) || act_q == 3'(rau_pkg::ACT_SUB))
               ? sum[63:0] : p1_q;
        gy_d = (act_q == 3'(rau_pkg::ACT_ADD) || act_q == 3'(rau_pkg::ACT_SUB))
               ? den_q : p2_q;
        if (act_q == 3'(rau_pkg::ACT_CMP)) begin
          state_d = rau_pkg::S_DONE;
        end else begin
          state_d = rau_pkg::S_GCD;
          dv_a = gx_d; dv_b = gy_d;
          dv_start = (gy_d != '0);
        end
      end
      // Euclid: one divider run per remainder step.
      rau_pkg::S_GCD: begin
        if (gy_q == '0) begin
          dv_a = num_q; dv_b = gx_q; dv_start = 1'b1;
          state_d = rau_pkg::S_DIVN;
        end else if (dv_done) begin
          gx_d = gy_q; gy_d = dv_r;
          if (dv_r != '0) begin
            dv_a = gy_q; dv_b = dv_r; dv_start = 1'b1;
          end
        end
      end
      rau_pkg::S_DIVN: begin
        if (dv_done) begin
          n_d = dv_q;
          dv_a = den_q; dv_b = gx_q; dv_start = 1'b1;
          state_d = rau_pkg::S_DIVD;
        end
      end
      rau_pkg::S_DIVD: begin
        if (dv_done) begin
          negx = (s1_q != s2_q) && n_q != '0;
          if (dv_q > maxpos || (negx ? n_q > maxpos + 64'd1 : n_q > maxpos)) begin
            st_d = rau_pkg::ST_OVF;
          end else begin
            rn_d = negx ? (32'd0 - n_q[31:0]) : n_q[31:0];
            rd_d = dv_q[30:0];
          end
          state_d = rau_pkg::S_DONE;
        end
      end
      rau_pkg::S_DONE: begin
        dn_d = 1'b1; state_d = rau_pkg::S_IDLE;
      end
      default: state_d = rau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::S_IDLE;
      dn_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      dn_q    <= dn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    p1_q <= p1_d; p2_q <= p2_d; s1_q <= s1_d; s2_q <= s2_d;
    num_q <= num_d; den_q <= den_d; gx_q <= gx_d; gy_q <= gy_d; n_q <= n_d;
    nneg_q <= nneg_d; rn_q <= rn_d; rd_q <= rd_d; ord_q <= ord_d; st_q <= st_d;
  end

  assign busy      = (state_q != rau_pkg::S_IDLE);
  assign done_o    = dn_q;
  assign res_num_o = dn_q ? rn_q : '0;
  assign res_den_o = dn_q ? rd_q : '0;
  assign order_o   = dn_q ? ord_q : '0;
  assign status_o  = dn_q ? st_q : '0;

  // A result beat only follows the closing state and leaves the unit idle.
  `RAU_ASSERT(a_done_src, clk_i, rst_ni, done_o |-> $past(state_q == rau_pkg::S_DONE), "done without closing state")
  `RAU_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy, "done while busy")
  `RAU_ASSERT(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accepted beat did not raise busy")
  `RAU_ASSERT(a_err_zero, clk_i, rst_ni, (done_o && status_o != rau_pkg::ST_OK) |-> (res_den_o == '0 && res_num_o == '0), "error result not zero")
endmodule

/* test/rational_arithmetic_unit_tb.sv */
// Testbench of the rational arithmetic unit: directed and random fraction beats,
// each result checked against a predictor of exact arithmetic with gcd reduction.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
  // Action codes that the block leaves unused.
  localparam logic [2:0] ACT_RSV6 = 3'd6;
  localparam logic [2:0] ACT_RSV7 = 3'd7;
  localparam int unsigned STALL_LIMIT = 50000;
  localparam int unsigned DRAIN_CYCLES = 2500;
  localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         ord;
    logic [1:0]         st;
  } fraction_result_t;

  typedef struct {
    bit        neg;
    bit [63:0] mag;
  } signed_mag_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] action_i = '0;
  logic signed [31:0] a_num_i = '0;
  logic signed [31:0] a_den_i = '0;
  logic signed [31:0] b_num_i = '0;
  logic signed [31:0] b_den_i = '0;
  logic done_o;
  logic signed [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic [1:0] order_o;
  logic [1:0] status_o;

  fraction_result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;

  rational_arithmetic_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .action_i(action_i), .a_num_i(a_num_i), .a_den_i(a_den_i),
    .b_num_i(b_num_i), .b_den_i(b_den_i), .done_o(done_o),
    .res_num_o(res_num_o), .res_den_o(res_den_o), .order_o(order_o),
    .status_o(status_o)
  );

  always #2 clk_i = ~clk_i;

  // Sign and magnitude helpers for exact cross products.
  function automatic signed_mag_t to_mag(longint v);
    signed_mag_t r;
    r.neg = v < 0;
    r.mag = v < 0 ? -v : v;
    return r;
  endfunction

  function automatic signed_mag_t mul_mag(longint x, longint y);
    signed_mag_t p, q, r;
    p = to_mag(x);
    q = to_mag(y);
    r.mag = p.mag * q.mag;
    r.neg = (p.neg != q.neg) && r.mag != 0;
    return r;
  endfunction

  function automatic signed_mag_t add_mag(signed_mag_t p, signed_mag_t q);
    signed_mag_t r;
    if (p.neg == q.neg) begin
      r.mag = p.mag + q.mag;
      r.neg = p.neg;
    end else if (p.mag >= q.mag) begin
      r.mag = p.mag - q.mag;
      r.neg = p.neg;
    end else begin
      r.mag = q.mag - p.mag;
      r.neg = q.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  // Reduce num/den by the gcd, move the sign up and check the 32-bit range.
  function automatic fraction_result_t reduce_fraction(signed_mag_t n, signed_mag_t d);
    fraction_result_t r;
    bit [63:0] x, y, t, rn, rd, maxpos;
    bit neg;
    r = '0;
    maxpos = 64'h7fffffff;
    if (d.mag == 0) begin
      r.st = rau_pkg::ST_ZDEN;
      return r;
    end
    x = n.mag;
    y = d.mag;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    rn = n.mag / x;
    rd = d.mag / x;
    neg = (n.neg != d.neg) && rn != 0;
    if (rd > maxpos || (neg ? rn > maxpos + 1 : rn > maxpos)) begin
      r.st = rau_pkg::ST_OVF;
      return r;
    end
    r.num = neg ? -rn[31:0] : rn[31:0];
    r.den = rd[30:0];
    return r;
  endfunction

  function automatic fraction_result_t predict_fraction(logic [2:0] act,
      logic signed [31:0] an, logic signed [31:0] ad,
      logic signed [31:0] bn, logic signed [31:0] bd);
    fraction_result_t r;
    signed_mag_t x, y;
    r = '0;
    if (act == ACT_RSV6 || act == ACT_RSV7) return r;
    if (act == rau_pkg::ACT_NEG) return reduce_fraction(to_mag(-longint'(an)), to_mag(ad));
    if (ad == 0 || bd == 0) begin
      r.st = rau_pkg::ST_ZDEN;
      return r;
    end
    case (act)
      rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
        x = mul_mag(an, bd);
        y = mul_mag(bn, ad);
        if (act == rau_pkg::ACT_SUB && y.mag != 0) y.neg = !y.neg;
        r = reduce_fraction(add_mag(x, y), mul_mag(ad, bd));
      end
      rau_pkg::ACT_MUL: r = reduce_fraction(mul_mag(an, bn), mul_mag(ad, bd));
      rau_pkg::ACT_DIV: r = reduce_fraction(mul_mag(an, bd), mul_mag(ad, bn));
      default: begin
        x = mul_mag(an, bd);
        y = mul_mag(bn, ad);
        if (y.mag != 0) y.neg = !y.neg;
        x = add_mag(x, y);
        if ((ad < 0) != (bd < 0) && x.mag != 0) x.neg = !x.neg;
        r.ord = x.mag == 0 ? rau_pkg::ORD_EQ : (x.neg ? rau_pkg::ORD_LT : rau_pkg::ORD_GT);
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // Sends one beat, waits for acceptance, then idles the sender at random.
  task automatic send_fraction(logic [2:0] act, logic signed [31:0] an,
      logic signed [31:0] ad, logic signed [31:0] bn, logic signed [31:0] bd);
    bit taken;
    action_i <= act;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    start <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    pending_results.push_back(predict_fraction(act, an, ad, bn, bd));
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Result checker and stall watchdog, both sampled away from the active edge.
  always @(negedge clk_i) begin
    fraction_result_t want;
    if (rst_ni) begin
      if (done_o || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("rational_arithmetic_unit_tb: errors");
        $finish;
      end
      if (done_o) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (res_num_o !== want.num) report_mismatch("res_num", res_num_o, want.num);
          if (res_den_o !== want.den) report_mismatch("res_den", res_den_o, want.den);
          if (order_o !== want.ord) report_mismatch("order", order_o, want.ord);
          if (status_o !== want.st) report_mismatch("status", status_o, want.st);
        end
      end
    end
  end

  function automatic logic signed [31:0] pick_operand(bit allow_zero);
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom_range(0, 40) - 20;
      2: v = $urandom;
      3: v = 32'sd1 <<< $urandom_range(0, 31);
      4: v = $urandom_range(0, 3) == 0 ? MIN32 : ($urandom_range(0, 1) ? MAX32 : -MAX32);
      default: v = $urandom_range(0, 2000) - 1000;
    endcase
    if (!allow_zero && v == 0) v = 1;
    return v;
  endfunction

  task automatic test_directed();
    send_fraction(rau_pkg::ACT_ADD, 1, 2, 1, 3);
    send_fraction(rau_pkg::ACT_SUB, 1, 2, 1, 2);
    send_fraction(rau_pkg::ACT_MUL, -3, 4, 2, -9);
    send_fraction(rau_pkg::ACT_DIV, 5, 6, -10, 3);
    send_fraction(rau_pkg::ACT_DIV, 5, 6, 0, 3);
    send_fraction(rau_pkg::ACT_CMP, 1, 3, 1, 2);
    send_fraction(rau_pkg::ACT_CMP, 2, -4, -1, 2);
    send_fraction(rau_pkg::ACT_CMP, 1, -3, 1, 2);
    send_fraction(rau_pkg::ACT_CMP, 3, 2, 1, 1);
    send_fraction(rau_pkg::ACT_NEG, 6, -8, 0, 0);
    send_fraction(rau_pkg::ACT_NEG, MIN32, 1, 0, 0);
    send_fraction(rau_pkg::ACT_NEG, MIN32, -1, 0, 0);
    send_fraction(rau_pkg::ACT_NEG, 7, 0, 1, 1);
    send_fraction(rau_pkg::ACT_ADD, 1, 0, 1, 1);
    send_fraction(rau_pkg::ACT_CMP, 1, 1, 1, 0);
    send_fraction(rau_pkg::ACT_ADD, MAX32, 1, 1, 1);
    send_fraction(rau_pkg::ACT_MUL, MIN32, MIN32, MIN32, MIN32);
    send_fraction(rau_pkg::ACT_MUL, MIN32, 1, -1, 1);
    send_fraction(rau_pkg::ACT_DIV, 1, MAX32, 1, MAX32 - 1);
    send_fraction(rau_pkg::ACT_SUB, MIN32, MAX32, MAX32, MIN32);
    send_fraction(rau_pkg::ACT_MUL, 0, -5, 9, 7);
    send_fraction(ACT_RSV6, 3, 4, 5, 6);
    send_fraction(ACT_RSV7, -1, -1, -1, -1);
  endtask

  task automatic test_random(int unsigned count);
    logic [2:0] act;
    bit zero_den;
    for (int unsigned i = 0; i < count; i++) begin
      act = $urandom_range(0, 99) < 4 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      zero_den = $urandom_range(0, 19) == 0;
      send_fraction(act, pick_operand(1'b1), pick_operand(zero_den),
                    pick_operand(1'b1), pick_operand(zero_den));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 36;
    test_directed();
    test_random(620);
    sender_idle_pct = 48;
    test_random(630);
    sender_idle_pct = 0;
    test_random(630);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("rational_arithmetic_unit_tb: clean");
    else $display("rational_arithmetic_unit_tb: errors");
    $finish;
  end
endmodule
